// ----- rtl/batp_pkg.sv -----
// Package for the bearing-to-point block: transaction types, angle constants,
// the sequencer state type and the CORDIC arctangent table.
// No dependencies.
package batp_pkg;

   // Input transaction: current and target position, 8 fraction bits.
   typedef struct packed {
      logic signed [23:0] cur_x;
      logic signed [23:0] cur_y;
      logic signed [23:0] dest_x;
      logic signed [23:0] dest_y;
   } req_type;

   // Result transaction: held heading in degrees (8 fraction bits) and update flag.
   typedef struct packed {
      logic [16:0] heading;
      logic        updated;
   } rsp_type;

   // Angles in degrees with 8 fraction bits.
   localparam logic [16:0] DEG0   = 17'd0;
   localparam logic [16:0] DEG90  = 17'd23040;
   localparam logic [16:0] DEG180 = 17'd46080;
   localparam logic [16:0] DEG270 = 17'd69120;
   localparam logic [16:0] DEG360 = 17'd92160;

   // Right angle with 16 fraction bits, the upper clamp of the CORDIC angle.
   localparam logic signed [24:0] Z_DEG90 = 25'sd5898240;
   // Half an output LSB, for rounding from 16 to 8 fraction bits.
   localparam logic signed [24:0] Z_HALF  = 25'sd128;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_R,
      ST_CMP,
      ST_ROT,
      ST_MAP,
      ST_OUT
   } state_type;

   // atan(2^-i) in degrees with 16 fraction bits.
   function automatic logic [21:0] atan_q16(input logic [4:0] idx);
      logic [21:0] val;
      begin
         unique case (idx)
            5'd0:    val = 22'd2949120;
            5'd1:    val = 22'd1740967;
            5'd2:    val = 22'd919879;
            5'd3:    val = 22'd466945;
            5'd4:    val = 22'd234379;
            5'd5:    val = 22'd117304;
            5'd6:    val = 22'd58666;
            5'd7:    val = 22'd29335;
            5'd8:    val = 22'd14668;
            5'd9:    val = 22'd7334;
            5'd10:   val = 22'd3667;
            5'd11:   val = 22'd1833;
            5'd12:   val = 22'd917;
            5'd13:   val = 22'd458;
            5'd14:   val = 22'd229;
            5'd15:   val = 22'd115;
            5'd16:   val = 22'd57;
            5'd17:   val = 22'd29;
            5'd18:   val = 22'd14;
            5'd19:   val = 22'd7;
            5'd20:   val = 22'd4;
            5'd21:   val = 22'd2;
            5'd22:   val = 22'd1;
            default: val = 22'd0;
         endcase
         return val;
      end
   endfunction

endpackage

// ----- rtl/bearing_angle_to_point_top.sv -----
// The heading is recomputed off-axis by the CORDIC rotation; when the target is inside
// the dead zone or on an axis, the rotation is skipped.
// A new transaction is taken only once the last result is handed over; the shared
// 25x25 multiplier (three squares) and the shared shift-add CORDIC rotator serve one at a time.
// Reset (synchronous, active high) clears the held heading to zero degrees and the
// dead-zone radius to zero, and empties the result register.
// Depends on batp_pkg.
module bearing_angle_to_point_top #(
   parameter int CORDIC_STEPS = 20
) (
   input  logic             clock,
   input  logic             reset,
   // Input channel
   input  logic             req_valid,
   output logic             req_stall,
   input  batp_pkg::req_type req_data,
   // Result channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output batp_pkg::rsp_type rsp_data,
   // Configuration write channel
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [22:0]      csr_data
);
   import batp_pkg::*;

   localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam logic [IW-1:0] LAST_STEP = IW'(CORDIC_STEPS - 1);

   // Control registers
   state_type      state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [16:0]    held_ff, held_in;
   logic [22:0]    radius_ff, radius_in;

   // Working registers
   logic [24:0]        ax_ff, ax_in;
   logic [24:0]        ay_ff, ay_in;
   logic               xneg_ff, xneg_in;
   logic               yneg_ff, yneg_in;
   logic               xzero_ff, xzero_in;
   logic               yzero_ff, yzero_in;
   logic [49:0]        prod_ff, prod_in;
   logic [49:0]        d2_ff, d2_in;
   logic               upd_ff, upd_in;
   logic signed [35:0] x_ff, x_in;
   logic signed [35:0] y_ff, y_in;
   logic signed [24:0] z_ff, z_in;
   logic [IW-1:0]      cnt_ff, cnt_in;
   rsp_type            rsp_ff, rsp_in;

   // Datapath signals
   logic signed [24:0] dx_c, dy_c;
   logic [24:0]        mul_a;
   logic [49:0]        prod_c;
   logic signed [35:0] xs_c, ys_c;
   logic signed [24:0] atan_s;
   logic signed [24:0] zc_c;
   logic signed [24:0] zr_c;
   logic [16:0]        ang_c;

   // Differences of the incoming transaction, sign-extended by one bit.
   assign dx_c = {req_data.dest_x[23], req_data.dest_x} - {req_data.cur_x[23], req_data.cur_x};
   assign dy_c = {req_data.dest_y[23], req_data.dest_y} - {req_data.cur_y[23], req_data.cur_y};

   // Shared squaring unit.
   always_comb begin
      case (state_ff)
         ST_SQ_X: mul_a = ax_ff;
         ST_SQ_Y: mul_a = ay_ff;
         default: mul_a = {2'b00, radius_ff};
      endcase
   end
   assign prod_c = mul_a * mul_a;

   // Shared CORDIC rotator: floor shifts by the step count and the table angle.
   assign xs_c   = x_ff >>> cnt_ff;
   assign ys_c   = y_ff >>> cnt_ff;
   assign atan_s = {3'b000, atan_q16(5'(cnt_ff))};

   // Clamp the accumulated angle to between zero and a right angle and round to 8 fraction bits.
   always_comb begin
      if (z_ff[24]) begin
         zc_c = '0;
      end else if (z_ff > Z_DEG90) begin
         zc_c = Z_DEG90;
      end else begin
         zc_c = z_ff;
      end
   end
   assign zr_c  = (zc_c + Z_HALF) >>> 8;
   assign ang_c = zr_c[16:0];

   // Sequencer: next state and next register values.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      held_in      = held_ff;
      radius_in    = radius_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      xneg_in      = xneg_ff;
      yneg_in      = yneg_ff;
      xzero_in     = xzero_ff;
      yzero_in     = yzero_ff;
      prod_in      = prod_c;
      d2_in        = d2_ff;
      upd_in       = upd_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      cnt_in       = cnt_ff;
      rsp_in       = rsp_ff;

      // The user must send configuration writes only while the block is idle; the block does not enforce it.
      if (csr_valid) begin
         radius_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ax_in    = dx_c[24] ? 25'(-dx_c) : 25'(dx_c);
               ay_in    = dy_c[24] ? 25'(-dy_c) : 25'(dy_c);
               xneg_in  = dx_c[24];
               yneg_in  = dy_c[24];
               xzero_in = (dx_c == '0);
               yzero_in = (dy_c == '0);
               state_in = ST_SQ_X;
            end
         end
         ST_SQ_X: begin
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            d2_in    = prod_ff;
            state_in = ST_SQ_R;
         end
         ST_SQ_R: begin
            d2_in    = d2_ff + prod_ff;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // prod_ff holds the squared radius here.
            if (d2_ff > prod_ff) begin
               upd_in = 1'b1;
               if (xzero_ff) begin
                  held_in  = yneg_ff ? DEG270 : DEG90;
                  state_in = ST_OUT;
               end else if (yzero_ff) begin
                  held_in  = xneg_ff ? DEG180 : DEG0;
                  state_in = ST_OUT;
               end else begin
                  x_in     = {3'b000, ax_ff, 8'h00};
                  y_in     = {3'b000, ay_ff, 8'h00};
                  z_in     = '0;
                  cnt_in   = '0;
                  state_in = ST_ROT;
               end
            end else begin
               upd_in   = 1'b0;
               state_in = ST_OUT;
            end
         end
         ST_ROT: begin
            // One vectoring iteration drives y towards zero.
            if (!y_ff[35]) begin
               x_in = x_ff + ys_c;
               y_in = y_ff - xs_c;
               z_in = z_ff + atan_s;
            end else begin
               x_in = x_ff - ys_c;
               y_in = y_ff + xs_c;
               z_in = z_ff - atan_s;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            // Map the first-quadrant angle into its quadrant; a full turn wraps to zero.
            if (!xneg_ff && !yneg_ff) begin
               held_in = ang_c;
            end else if (xneg_ff && !yneg_ff) begin
               held_in = DEG180 - ang_c;
            end else if (xneg_ff) begin
               held_in = DEG180 + ang_c;
            end else if (ang_c == DEG0) begin
               held_in = DEG0;
            end else begin
               held_in = DEG360 - ang_c;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Hand the result over once the result register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.heading = held_ff;
               rsp_in.updated = upd_ff;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         held_ff      <= DEG0;
         radius_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         held_ff      <= held_in;
         radius_ff    <= radius_in;
      end
   end

   // Working and result payload registers.
   always_ff @(posedge clock) begin
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      xneg_ff  <= xneg_in;
      yneg_ff  <= yneg_in;
      xzero_ff <= xzero_in;
      yzero_ff <= yzero_in;
      prod_ff  <= prod_in;
      d2_ff    <= d2_in;
      upd_ff   <= upd_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      cnt_ff   <= cnt_in;
      rsp_ff   <= rsp_in;
   end

   // Ports.
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule
